>>> rtl/bars_pkg.sv
// Package for the button auto-repeat scale adjuster.
// Holds item structs, register codes, reset defaults and shared config types.
// No dependencies.
package bars_pkg;

  // Default widths of the scales and of the tick timers
  localparam int unsigned ScaleBitsDef = 16;
  localparam int unsigned TimerBitsDef = 16;

  // Register reset values
  localparam logic [15:0] StepSizeRst       = 16'd10;
  localparam logic [9:0]  TickTimeRst       = 10'd10;
  localparam logic [14:0] HoldWaitRst       = 15'd500;
  localparam logic [14:0] RepeatIntervalRst = 15'd100;
  localparam logic        TankModeRst       = 1'b0;
  localparam logic [15:0] LeftStartRst      = 16'd0;
  localparam logic [15:0] RightStartRst     = 16'd0;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned NumButtons  = 4;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_STEP_SIZE       = 3'd0,
    CFG_TICK_TIME       = 3'd1,
    CFG_HOLD_WAIT       = 3'd2,
    CFG_REPEAT_INTERVAL = 3'd3,
    CFG_TANK_MODE       = 3'd4,
    CFG_LEFT_START      = 3'd5,
    CFG_RIGHT_START     = 3'd6
  } cfg_idx_e;

  // Input item: one tick with four button levels
  typedef struct packed {
    logic left_up_btn;
    logic left_down_btn;
    logic right_up_btn;
    logic right_down_btn;
  } in_item_t;

  // Result item: both scales and the release save pulses
  typedef struct packed {
    logic [15:0] left_scale;
    logic [15:0] right_scale;
    logic        save_left;
    logic        save_right;
  } out_item_t;

  // Timing and step settings shared by every button
  typedef struct packed {
    logic [15:0] step_size;
    logic [9:0]  tick_time;
    logic [14:0] hold_wait;
    logic [14:0] repeat_interval;
  } timing_cfg_t;

  // Per-button control flags
  typedef struct packed {
    logic held_lock;
    logic save_pending;
  } btn_flags_t;

endpackage

>>> rtl/bars_btn.sv
// One button of the auto-repeat chain: press step, hold repeat, release save.
// Pure combinational next-state logic; depends on bars_pkg.
module bars_btn #(
  parameter int unsigned SCALE_BITS = bars_pkg::ScaleBitsDef,
  parameter int unsigned TIMER_BITS = bars_pkg::TimerBitsDef
) (
  input  logic                    level_i,
  input  logic                    up_i,
  input  bars_pkg::timing_cfg_t   cfg_i,
  input  logic [SCALE_BITS-1:0]   scale_i,
  input  bars_pkg::btn_flags_t    flags_i,
  input  logic [TIMER_BITS-1:0]   hold_i,
  input  logic [TIMER_BITS-1:0]   rel_i,
  input  logic [TIMER_BITS-1:0]   racc_i,
  output logic [SCALE_BITS-1:0]   scale_o,
  output bars_pkg::btn_flags_t    flags_o,
  output logic [TIMER_BITS-1:0]   hold_o,
  output logic [TIMER_BITS-1:0]   rel_o,
  output logic [TIMER_BITS-1:0]   racc_o,
  output logic                    save_o
);
  import bars_pkg::*;

  // Working widths for the saturating sums and compares
  localparam int unsigned TW = ((TIMER_BITS > 10) ? TIMER_BITS : 10) + 1;
  localparam int unsigned CW = ((TIMER_BITS + 1 > 15) ? TIMER_BITS + 1 : 15) + 1;
  localparam int unsigned SW = ((SCALE_BITS > 16) ? SCALE_BITS : 16) + 1;
  localparam logic [TIMER_BITS-1:0] TimerMax = {TIMER_BITS{1'b1}};
  localparam logic [SCALE_BITS-1:0] ScaleMax = {SCALE_BITS{1'b1}};

  // Add one tick to a timer, saturating at its maximum
  function automatic logic [TIMER_BITS-1:0] timer_add(input logic [TIMER_BITS-1:0] t,
                                                      input logic [9:0] tick);
    logic [TW-1:0] sum;
    sum = TW'(t) + TW'(tick);
    return (sum > TW'(TimerMax)) ? TimerMax : TIMER_BITS'(sum);
  endfunction

  // Apply one step up (saturate) or down (floor at zero)
  function automatic logic [SCALE_BITS-1:0] apply_step(input logic [SCALE_BITS-1:0] v,
                                                       input logic [15:0] step,
                                                       input logic up);
    logic [SW-1:0] sum;
    logic [SW-1:0] res;
    sum = SW'(v) + SW'(step);
    res = SW'(v) - SW'(step);
    if (up) begin
      return (sum > SW'(ScaleMax)) ? ScaleMax : SCALE_BITS'(sum);
    end
    return (SW'(v) > SW'(step)) ? SCALE_BITS'(res) : '0;
  endfunction

  logic [TIMER_BITS-1:0] hold_inc;
  logic [TIMER_BITS-1:0] racc_inc;
  logic [TIMER_BITS-1:0] rel_inc;
  logic [SCALE_BITS-1:0] stepped;

  assign hold_inc = timer_add(hold_i, cfg_i.tick_time);
  assign racc_inc = timer_add(racc_i, cfg_i.tick_time);
  assign rel_inc  = timer_add(rel_i, cfg_i.tick_time);
  assign stepped  = apply_step(scale_i, cfg_i.step_size, up_i);

  // Press, hold and release handling
  always_comb begin
    scale_o = scale_i;
    flags_o = flags_i;
    hold_o  = hold_i;
    rel_o   = rel_i;
    racc_o  = racc_i;
    save_o  = 1'b0;
    if (level_i && !flags_i.held_lock) begin
      scale_o              = stepped;
      flags_o.held_lock    = 1'b1;
      flags_o.save_pending = 1'b1;
    end else if (level_i) begin
      hold_o = hold_inc;
      if (CW'(hold_inc) > CW'(cfg_i.hold_wait)) begin
        racc_o = racc_inc;
        if (CW'(racc_inc) > CW'(cfg_i.repeat_interval)) begin
          scale_o = stepped;
          racc_o  = '0;
        end
      end
    end else begin
      flags_o.held_lock = 1'b0;
      hold_o            = '0;
      if (flags_i.save_pending) begin
        rel_o = rel_inc;
        if (CW'({rel_inc, 1'b0}) > CW'(cfg_i.hold_wait)) begin
          rel_o                = '0;
          flags_o.save_pending = 1'b0;
          save_o               = 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/button_autorepeat_scale_adjust.sv
// Top level of the button auto-repeat scale adjuster; holds registers and state.
// Depends on bars_pkg and bars_btn.
//
// Each input item is one control tick with four button levels. The block takes
// one item every clock cycle while the result is not stalled. The input register
// takes the item when it is accepted; the four-button chain then resolves into
// the result register, which also updates the per-button state. A stalled result
// holds both stages, and the input stage frees as soon as the result is taken.
// Write configuration only while the block is idle; writing left_start or
// right_start also loads that scale. Scales are unsigned hundredths; outputs show
// their low 16 bits.
module button_autorepeat_scale_adjust #(
  parameter int unsigned SCALE_BITS = bars_pkg::ScaleBitsDef,
  parameter int unsigned TIMER_BITS = bars_pkg::TimerBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bars_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [bars_pkg::CfgDataBits-1:0]   cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bars_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bars_pkg::out_item_t                out_item_o
);
  import bars_pkg::*;

  localparam int unsigned OW = (SCALE_BITS > 16) ? SCALE_BITS : 16;
  localparam int unsigned NB = NumButtons;

  // Configuration registers
  timing_cfg_t cfg_q;
  logic        tank_q;

  // Pipeline registers
  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_q;
  logic      res_valid_q, res_valid_d;
  out_item_t res_q, res_d;

  // Scale and button state
  logic [SCALE_BITS-1:0] left_q, left_d;
  logic [SCALE_BITS-1:0] right_q, right_d;
  btn_flags_t            flags_q [NB];
  btn_flags_t            flags_d [NB];
  logic [TIMER_BITS-1:0] hold_q  [NB];
  logic [TIMER_BITS-1:0] hold_d  [NB];
  logic [TIMER_BITS-1:0] rel_q   [NB];
  logic [TIMER_BITS-1:0] rel_d   [NB];
  logic [TIMER_BITS-1:0] racc_q  [NB];
  logic [TIMER_BITS-1:0] racc_d  [NB];

  // Chain wiring
  logic                  level [NB];
  logic [SCALE_BITS-1:0] sc_in  [NB];
  logic [SCALE_BITS-1:0] sc_out [NB];
  btn_flags_t            fl_out [NB];
  logic [TIMER_BITS-1:0] hd_out [NB];
  logic [TIMER_BITS-1:0] rl_out [NB];
  logic [TIMER_BITS-1:0] ra_out [NB];
  logic                  sv_out [NB];

  logic          advance;
  logic          in_acc;
  logic          fire;
  logic [OW-1:0] left_ext;
  logic [OW-1:0] right_ext;

  // Handshake: the result side frees the pipeline
  assign advance    = !res_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fire       = s1_valid_q && advance;
  assign s1_valid_d = in_acc || (s1_valid_q && !advance);
  assign res_valid_d = advance ? s1_valid_q : res_valid_q;

  // Button chain: left up, left down, right up, right down
  assign level[0] = s1_q.left_up_btn;
  assign level[1] = s1_q.left_down_btn;
  assign level[2] = s1_q.right_up_btn;
  assign level[3] = s1_q.right_down_btn;
  assign sc_in[0] = left_q;
  assign sc_in[1] = sc_out[0];
  assign sc_in[2] = right_q;
  assign sc_in[3] = sc_out[2];

  for (genvar b = 0; b < NB; b++) begin : g_btn
    bars_btn #(
      .SCALE_BITS(SCALE_BITS),
      .TIMER_BITS(TIMER_BITS)
    ) u_btn (
      .level_i (level[b]),
      .up_i    ((b % 2) == 0),
      .cfg_i   (cfg_q),
      .scale_i (sc_in[b]),
      .flags_i (flags_q[b]),
      .hold_i  (hold_q[b]),
      .rel_i   (rel_q[b]),
      .racc_i  (racc_q[b]),
      .scale_o (sc_out[b]),
      .flags_o (fl_out[b]),
      .hold_o  (hd_out[b]),
      .rel_o   (rl_out[b]),
      .racc_o  (ra_out[b]),
      .save_o  (sv_out[b])
    );

    // Freeze the right pair in tank mode
    if (b < 2) begin : g_left
      assign flags_d[b] = fl_out[b];
      assign hold_d[b]  = hd_out[b];
      assign rel_d[b]   = rl_out[b];
      assign racc_d[b]  = ra_out[b];
    end else begin : g_right
      assign flags_d[b] = tank_q ? flags_q[b] : fl_out[b];
      assign hold_d[b]  = tank_q ? hold_q[b]  : hd_out[b];
      assign rel_d[b]   = tank_q ? rel_q[b]   : rl_out[b];
      assign racc_d[b]  = tank_q ? racc_q[b]  : ra_out[b];
    end
  end

  // Build the result item
  assign left_d    = sc_out[1];
  assign right_d   = tank_q ? right_q : sc_out[3];
  assign left_ext  = OW'(left_d);
  assign right_ext = OW'(right_d);

  always_comb begin
    res_d             = res_q;
    res_d.left_scale  = left_ext[15:0];
    res_d.right_scale = right_ext[15:0];
    res_d.save_left   = sv_out[0] || sv_out[1];
    res_d.save_right  = !tank_q && (sv_out[2] || sv_out[3]);
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size       <= StepSizeRst;
      cfg_q.tick_time       <= TickTimeRst;
      cfg_q.hold_wait       <= HoldWaitRst;
      cfg_q.repeat_interval <= RepeatIntervalRst;
      tank_q                <= TankModeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STEP_SIZE:       cfg_q.step_size       <= cfg_wdata_i;
        CFG_TICK_TIME:       cfg_q.tick_time       <= cfg_wdata_i[9:0];
        CFG_HOLD_WAIT:       cfg_q.hold_wait       <= cfg_wdata_i[14:0];
        CFG_REPEAT_INTERVAL: cfg_q.repeat_interval <= cfg_wdata_i[14:0];
        CFG_TANK_MODE:       tank_q                <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Scales: preset on start writes, else advance on each processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= SCALE_BITS'(LeftStartRst);
      right_q <= SCALE_BITS'(RightStartRst);
    end else if (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_LEFT_START)) begin
      left_q <= SCALE_BITS'(cfg_wdata_i);
    end else if (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_RIGHT_START)) begin
      right_q <= SCALE_BITS'(cfg_wdata_i);
    end else if (fire) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  // Per-button state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NB; i++) begin
        flags_q[i] <= '0;
        hold_q[i]  <= '0;
        rel_q[i]   <= '0;
        racc_q[i]  <= TIMER_BITS'(RepeatIntervalRst);
      end
    end else if (fire) begin
      for (int i = 0; i < NB; i++) begin
        flags_q[i] <= flags_d[i];
        hold_q[i]  <= hold_d[i];
        rel_q[i]   <= rel_d[i];
        racc_q[i]  <= racc_d[i];
      end
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_item_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_q;

`ifndef SYNTH
  // The input stage only pushes back while it holds an item
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input stage");

  // No right save in tank mode
  a_tank_no_save: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && tank_q) |=> !res_q.save_right)
    else $error("right save fired in tank mode");

  // A pressed left up button is locked after its item
  a_press_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_q.left_up_btn) |=> flags_q[0].held_lock)
    else $error("left up press did not set its hold lock");

  // Both left buttons held means no left release save
  a_held_no_save: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_q.left_up_btn && s1_q.left_down_btn) |=> !res_q.save_left)
    else $error("left save fired while both left buttons held");

  // A processed item always produces a valid result
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("processed item gave no result");
`endif

endmodule
